### rtl/lcdd_pkg.sv
package lcdd_pkg;

  // widths of the fixed fields
  localparam int unsigned HalfW   = 16;
  localparam int unsigned ShiftW  = 11;
  localparam int unsigned CountW  = 4;
  localparam int unsigned NibW    = 4;
  localparam int unsigned AddrW   = 6;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 16;

  // lengths after the first bit: leading 1 of a header, top bit of a nibble
  localparam logic [CountW-1:0] CmdBits   = 4'd11;
  localparam logic [CountW-1:0] StartBits = 4'd8;
  localparam logic [CountW-1:0] NibBits   = 4'd3;

  // configuration register indexes
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgReadEnable = 1'b1;

  localparam logic [HalfW-1:0] HalfPeriodReset = 16'd50;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GAP,
    PH_WBIT,
    PH_RBIT
  } phase_e;

  typedef enum logic [FuncW-1:0] {
    FN_TICK     = 3'd0,
    FN_CMD      = 3'd1,
    FN_WR_START = 3'd2,
    FN_WR_NIB   = 3'd3,
    FN_RD_START = 3'd4,
    FN_RD_NIB   = 3'd5
  } func_e;

  typedef struct packed {
    phase_e              phase;
    logic [ShiftW-1:0]   shift_out;
    logic [CountW-1:0]   bits_left;
    logic [HalfW-1:0]    half_count;
    logic                second_half;
    logic                reading;
    logic                release_after;
    logic [NibW-1:0]     read_shift;
    logic                selected;
    logic                data_level;
  } state_t;

  localparam state_t StateReset = '{
    phase:         PH_IDLE,
    shift_out:     '0,
    bits_left:     '0,
    half_count:    '0,
    second_half:   1'b0,
    reading:       1'b0,
    release_after: 1'b0,
    read_shift:    '0,
    selected:      1'b0,
    data_level:    1'b1
  };

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [CodeW-1:0] command_code;
    logic [AddrW-1:0] address;
    logic [NibW-1:0]  nibble;
    logic             last;
    logic             data_in;
  } item_t;

  typedef struct packed {
    logic            rejected;
    logic [NibW-1:0] read_nibble;
    logic            read_valid;
    logic            busy_res;
    logic            data_out;
    logic            rd_n;
    logic            wr_n;
    logic            cs_n;
  } result_t;

endpackage

### rtl/lcdd_step.sv
module lcdd_step import lcdd_pkg::*; (
  input  state_t             cur_i,
  input  item_t              item_i,
  input  logic [HalfW-1:0]   half_period_i,
  input  logic               read_enable_i,
  output state_t             nxt_o,
  output result_t            res_o
);

  logic [HalfW-1:0]  reload;
  logic [15:0]       shift_ext;
  logic [CountW-1:0] bits_dec;
  logic              rej;
  logic              valid;
  state_t            nxt;

  // zero half period acts as one tick
  assign reload    = (half_period_i == '0) ? '0 : half_period_i - 16'd1;
  assign shift_ext = {5'b0, cur_i.shift_out};
  assign bits_dec  = cur_i.bits_left - 4'd1;

  // one tick of the serial engine, or the start of a new request
  always_comb begin
    nxt   = cur_i;
    rej   = 1'b0;
    valid = 1'b0;
    if (cur_i.phase != PH_IDLE) begin
      rej = (item_i.func != FN_TICK);
      if (cur_i.half_count != '0) begin
        nxt.half_count = cur_i.half_count - 16'd1;
      end else begin
        unique case (cur_i.phase)
          PH_GAP: begin
            if (!cur_i.second_half) begin
              nxt.second_half = 1'b1;
            end else begin
              // header always opens with a 1
              nxt.selected    = 1'b1;
              nxt.data_level  = 1'b1;
              nxt.phase       = PH_WBIT;
              nxt.second_half = 1'b0;
            end
            nxt.half_count = reload;
          end
          PH_WBIT: begin
            if (!cur_i.second_half) begin
              nxt.second_half = 1'b1;
              nxt.half_count  = reload;
            end else if (cur_i.bits_left != '0) begin
              nxt.bits_left   = bits_dec;
              nxt.data_level  = shift_ext[bits_dec];
              nxt.second_half = 1'b0;
              nxt.half_count  = reload;
            end else begin
              nxt.phase       = PH_IDLE;
              nxt.second_half = 1'b0;
              if (cur_i.release_after) nxt.selected = 1'b0;
            end
          end
          PH_RBIT: begin
            if (!cur_i.second_half) begin
              // sample on the rising read strobe
              nxt.read_shift  = {cur_i.read_shift[NibW-2:0], item_i.data_in};
              nxt.second_half = 1'b1;
              nxt.half_count  = reload;
            end else if (cur_i.bits_left != '0) begin
              nxt.bits_left   = bits_dec;
              nxt.second_half = 1'b0;
              nxt.half_count  = reload;
            end else begin
              nxt.phase       = PH_IDLE;
              nxt.second_half = 1'b0;
              if (cur_i.release_after) nxt.selected = 1'b0;
              valid = 1'b1;
            end
          end
          default: begin
            nxt.phase = PH_IDLE;
          end
        endcase
      end
    end else begin
      unique case (item_i.func)
        FN_TICK: begin
        end
        FN_CMD, FN_WR_START: begin
          if (item_i.func == FN_CMD) begin
            nxt.shift_out     = {2'b00, item_i.command_code, 1'b1};
            nxt.bits_left     = CmdBits;
            nxt.release_after = 1'b1;
          end else begin
            nxt.shift_out     = {4'b0000, 1'b1, item_i.address};
            nxt.bits_left     = StartBits;
            nxt.release_after = 1'b0;
          end
          nxt.reading     = 1'b0;
          nxt.selected    = 1'b0;
          nxt.phase       = PH_GAP;
          nxt.second_half = 1'b0;
          nxt.half_count  = reload;
        end
        FN_RD_START: begin
          if (read_enable_i) begin
            nxt.shift_out     = {3'b000, 2'b10, item_i.address};
            nxt.bits_left     = StartBits;
            nxt.release_after = 1'b0;
            nxt.reading       = 1'b1;
            nxt.selected      = 1'b0;
            nxt.phase         = PH_GAP;
            nxt.second_half   = 1'b0;
            nxt.half_count    = reload;
          end else begin
            rej = 1'b1;
          end
        end
        FN_WR_NIB: begin
          if (cur_i.selected && !cur_i.reading) begin
            nxt.data_level    = item_i.nibble[NibW-1];
            nxt.shift_out     = {8'd0, item_i.nibble[NibW-2:0]};
            nxt.bits_left     = NibBits;
            nxt.release_after = item_i.last;
            nxt.phase         = PH_WBIT;
            nxt.second_half   = 1'b0;
            nxt.half_count    = reload;
          end else begin
            rej = 1'b1;
          end
        end
        FN_RD_NIB: begin
          if (cur_i.selected && cur_i.reading && read_enable_i) begin
            // release the data line before the read slots
            nxt.data_level    = 1'b1;
            nxt.read_shift    = '0;
            nxt.bits_left     = NibBits;
            nxt.release_after = item_i.last;
            nxt.phase         = PH_RBIT;
            nxt.second_half   = 1'b0;
            nxt.half_count    = reload;
          end else begin
            rej = 1'b1;
          end
        end
        default: begin
          rej = 1'b1;
        end
      endcase
    end
  end

  // pin levels and status after this tick
  always_comb begin
    res_o.cs_n        = (nxt.phase == PH_GAP) || !nxt.selected;
    res_o.wr_n        = !((nxt.phase == PH_WBIT) && !nxt.second_half);
    res_o.rd_n        = !((nxt.phase == PH_RBIT) && !nxt.second_half);
    res_o.data_out    = nxt.data_level;
    res_o.busy_res    = (nxt.phase != PH_IDLE);
    res_o.read_valid  = valid;
    res_o.read_nibble = valid ? nxt.read_shift : '0;
    res_o.rejected    = rej;
  end

  assign nxt_o = nxt;

endmodule

### rtl/lcdd_out_reg.sv
module lcdd_out_reg import lcdd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  result_t             res_i,
  output logic                ready_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot frees up in the same cycle the word leaves
  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

endmodule

### rtl/lcd_driver_three_wire_serial_master.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: request word, tlast: last nibble
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: pin levels and status word
// cfg       in   cfg_we_i                      cfg_idx_i selects register, cfg_data_i
//
// One word per clock unless stalled: each accepted input word advances the serial
// engine by one tick and yields one output word, registered for the next cycle.
// The engine update is a single pass of next-state logic on the state register.
// Reset puts the engine idle with chip select high and the data line at 1.
// Input is stalled only while an output word waits and m_axis_tready is low.
module lcd_driver_three_wire_serial_master import lcdd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func[2:0], command_code[10:3], address[16:11], nibble[20:17], data_in[21]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // cs_n[0], wr_n[1], rd_n[2], data_out[3], busy_res[4], read_valid[5],
  // read_nibble[9:6], rejected[10]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [HalfW-1:0]    cfg_data_i
);

  state_t           state_q, state_d;
  logic [HalfW-1:0] half_period_q;
  logic             read_enable_q;
  item_t            item;
  result_t          res;
  logic             accept;

  // unpack the request word
  always_comb begin
    item.func         = s_axis_tdata[2:0];
    item.command_code = s_axis_tdata[10:3];
    item.address      = s_axis_tdata[16:11];
    item.nibble       = s_axis_tdata[20:17];
    item.last         = s_axis_tlast;
    item.data_in      = s_axis_tdata[21];
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
      read_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: half_period_q <= cfg_data_i;
        CfgReadEnable: read_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  lcdd_step u_step (
    .cur_i         (state_q),
    .item_i        (item),
    .half_period_i (half_period_q),
    .read_enable_i (read_enable_q),
    .nxt_o         (state_d),
    .res_o         (res)
  );

  // engine state advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  lcdd_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .res_i         (res),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a completed read always leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4])
    else $error("read_valid while busy");

  // read data is zero unless a read completed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[5] |-> (m_axis_tdata[9:6] == 4'd0))
    else $error("read nibble without read_valid");

  // strobes never both low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] || m_axis_tdata[2]))
    else $error("write and read strobe low together");

  // idle engine always has the half flag clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> !state_q.second_half)
    else $error("half flag set while idle");

endmodule
